/* sv/bvg_pkg.sv */
// constants, tables and helpers of the battery voltage gauge
package bvg_pkg;

	// history ring
	localparam int HIST_DEPTH  = 10;
	localparam int HIST_SLOT_W = $clog2(HIST_DEPTH);
	localparam logic [HIST_SLOT_W-1:0] RISE_MIN_SLOT = HIST_SLOT_W'(3);

	typedef logic [12:0] mv_t;

	// reset values
	localparam logic [13:0] SCALE_RESET = 14'd8008;
	localparam logic [16:0] Q4_RESET    = 17'd62400;
	localparam mv_t         MV_RESET    = 13'd3900;

	// limits and thresholds, millivolts with 4 fraction bits but MV_MAX in whole millivolts
	localparam logic [16:0] Q4_MAX      = 17'd131071;
	localparam mv_t         MV_MAX      = 13'd8191;
	localparam logic [17:0] WIN_LOW_Q4  = 18'd32000;
	localparam logic [17:0] WIN_HIGH_Q4 = 18'd80000;
	localparam logic [16:0] FULL_Q4     = 17'd66720;
	localparam logic [16:0] CHARGING_Q4 = 17'd64800;
	localparam logic [17:0] RISE_Q4     = 18'd192;
	localparam logic [25:0] SCALE_ROUND = 26'd128;

	// item kind
	localparam logic KIND_SEED = 1'b1;

	// charge state codes
	localparam logic [1:0] CS_FULL        = 2'd0;
	localparam logic [1:0] CS_CHARGING    = 2'd1;
	localparam logic [1:0] CS_DISCHARGING = 2'd2;

	// state of charge table, voltages in Q4 millivolts, falling
	localparam int TABLE_POINTS = 12;
	localparam logic [16:0] SOC_MV_Q4 [TABLE_POINTS] = '{
		17'd67200, 17'd65600, 17'd64000, 17'd62400, 17'd61280, 17'd60480,
		17'd59680, 17'd58880, 17'd57920, 17'd56320, 17'd54400, 17'd51200
	};
	localparam logic [6:0] SOC_PCT [TABLE_POINTS] = '{
		7'd100, 7'd92, 7'd82, 7'd68, 7'd55, 7'd45,
		7'd35, 7'd24, 7'd15, 7'd7, 7'd2, 7'd0
	};

	// Q4 millivolts to whole millivolts, half up, saturated
	function automatic mv_t to_mv(input logic [16:0] q4);
		logic [17:0] t;
		logic [13:0] mv;
		t  = {1'b0, q4} + 18'd8;
		mv = t[17:4];
		return (mv > {1'b0, MV_MAX}) ? MV_MAX : mv[12:0];
	endfunction

endpackage

/* sv/battery_voltage_gauge_top.sv */
// battery voltage gauge: scaling, smoothing, history ring and charge estimate
//
//  channel   signals                        width  moves
//  s_axis    tvalid tready tdata tuser      16+1   one reading per transaction
//  m_axis    tvalid tready tdata            24     one report per transaction
//  cfg       valid ready data               14     divider ratio, Q2.12
//
// An item is taken in idle, then runs multiply, update, history, prepare,
// four divide steps and a finish cycle. The one shared multiplier and the
// 4-step restoring divider set this sequence. The report sits in an output
// register, so the next item is taken while it waits; a stalled report holds
// the finish cycle.
// Reset restores the ratio, the 3900 mV average and a history of 3900 mV.
module battery_voltage_gauge_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // adc_mv[11:0], history_tick[12], zero[15:13]
	input  logic        s_axis_tuser,   // kind[0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // voltage_mv[12:0], percent[19:13],
	                                    // charge_state[21:20], reading_accepted[22],
	                                    // zero[23]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [13:0] cfg_data
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_UPD  = 3'd2;
	localparam logic [2:0] ST_HIST = 3'd3;
	localparam logic [2:0] ST_PREP = 3'd4;
	localparam logic [2:0] ST_DIV  = 3'd5;
	localparam logic [2:0] ST_FIN  = 3'd6;

	logic [2:0]  state_q;
	logic        kind_q;
	logic [11:0] adc_q;
	logic        tick_q;
	logic [13:0] scale_q;
	logic [17:0] r_q;
	logic [16:0] smooth_q;
	logic        acc_q;
	bvg_pkg::mv_t hist_q [bvg_pkg::HIST_DEPTH];
	logic [bvg_pkg::HIST_SLOT_W-1:0] slot_q;
	logic        wrapped_q;
	logic [6:0]  base_q;
	logic [11:0] diff_q;
	logic [3:0]  dp_q;
	logic [11:0] den_q;
	logic [16:0] rem_q;
	logic [12:0] denom_q;
	logic [3:0]  quo_q;
	logic [1:0]  bit_q;
	logic [1:0]  cs_q;
	logic        out_valid_q;
	logic [23:0] out_data_q;

	logic [11:0] mul_a;
	logic [13:0] mul_b;
	logic [25:0] mul_p;
	logic [25:0] scaled;
	logic [19:0] filt;
	bvg_pkg::mv_t mv_now;
	logic [6:0]  seg_base;
	logic [11:0] seg_diff;
	logic [3:0]  seg_dp;
	logic [11:0] seg_den;
	logic [17:0] rise_thr;
	logic        rise;
	logic [1:0]  cs_next;
	logic [16:0] dsh;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// shared multiplier: reading times ratio, then offset times percent span
	always_comb begin
		if (state_q == ST_PREP) begin
			mul_a = diff_q;
			mul_b = {10'd0, dp_q};
		end else begin
			mul_a = adc_q;
			mul_b = scale_q;
		end
	end
	assign mul_p  = {14'd0, mul_a} * {12'd0, mul_b};
	assign scaled = mul_p + bvg_pkg::SCALE_ROUND;

	// quarter-step average
	assign filt = {2'd0, smooth_q, 1'b0} + {3'd0, smooth_q} + {2'd0, r_q} + 20'd2;

	assign mv_now = bvg_pkg::to_mv(smooth_q);

	// table segment of the smoothed voltage
	always_comb begin
		logic [16:0] d;
		logic [16:0] w;
		logic [6:0]  p;
		d        = '0;
		w        = '0;
		p        = '0;
		seg_base = 7'd0;
		seg_diff = 12'd0;
		seg_dp   = 4'd0;
		seg_den  = 12'd16;
		for (int i = bvg_pkg::TABLE_POINTS - 1; i >= 1; i--) begin
			if (smooth_q >= bvg_pkg::SOC_MV_Q4[i]) begin
				d = smooth_q - bvg_pkg::SOC_MV_Q4[i];
				w = bvg_pkg::SOC_MV_Q4[i-1] - bvg_pkg::SOC_MV_Q4[i];
				p = bvg_pkg::SOC_PCT[i-1] - bvg_pkg::SOC_PCT[i];
				seg_base = bvg_pkg::SOC_PCT[i];
				seg_diff = d[11:0];
				seg_den  = w[11:0];
				seg_dp   = p[3:0];
			end
		end
		if (smooth_q >= bvg_pkg::SOC_MV_Q4[0]) begin
			seg_base = bvg_pkg::SOC_PCT[0];
			seg_diff = 12'd0;
			seg_dp   = 4'd0;
			seg_den  = 12'd16;
		end
	end

	// charge judgement against the oldest history entry
	assign rise_thr = {1'b0, hist_q[slot_q], 4'd0} + bvg_pkg::RISE_Q4;
	assign rise = (wrapped_q || (slot_q > bvg_pkg::RISE_MIN_SLOT)) &&
	              ({1'b0, smooth_q} > rise_thr);
	always_comb begin
		if (smooth_q >= bvg_pkg::FULL_Q4) begin
			cs_next = bvg_pkg::CS_FULL;
		end else if (smooth_q >= bvg_pkg::CHARGING_Q4 || rise) begin
			cs_next = bvg_pkg::CS_CHARGING;
		end else begin
			cs_next = bvg_pkg::CS_DISCHARGING;
		end
	end

	// divisor shifted to the current quotient bit
	assign dsh = {4'd0, denom_q} << bit_q;

	// divider ratio register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= bvg_pkg::SCALE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			scale_q <= cfg_data;
		end
	end

	// sequencer and filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			smooth_q  <= bvg_pkg::Q4_RESET;
			slot_q    <= '0;
			wrapped_q <= 1'b0;
			for (int i = 0; i < bvg_pkg::HIST_DEPTH; i++) begin
				hist_q[i] <= bvg_pkg::MV_RESET;
			end
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					if (kind_q == bvg_pkg::KIND_SEED) begin
						smooth_q <= (r_q > {1'b0, bvg_pkg::Q4_MAX}) ? bvg_pkg::Q4_MAX
						                                             : r_q[16:0];
					end else if (r_q > bvg_pkg::WIN_LOW_Q4 && r_q < bvg_pkg::WIN_HIGH_Q4) begin
						smooth_q <= filt[18:2];
					end
					state_q <= ST_HIST;
				end
				ST_HIST: begin
					if (kind_q == bvg_pkg::KIND_SEED) begin
						for (int i = 0; i < bvg_pkg::HIST_DEPTH; i++) begin
							hist_q[i] <= mv_now;
						end
						slot_q    <= '0;
						wrapped_q <= 1'b0;
					end else if (tick_q) begin
						hist_q[slot_q] <= mv_now;
						if (slot_q == bvg_pkg::HIST_SLOT_W'(bvg_pkg::HIST_DEPTH - 1)) begin
							slot_q    <= '0;
							wrapped_q <= 1'b1;
						end else begin
							slot_q <= slot_q + bvg_pkg::HIST_SLOT_W'(1);
						end
					end
					state_q <= ST_PREP;
				end
				ST_PREP: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (bit_q == 2'd0) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (!out_valid_q || m_axis_tready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// working registers of one item
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				kind_q <= s_axis_tuser;
				adc_q  <= s_axis_tdata[11:0];
				tick_q <= s_axis_tdata[12];
			end
			ST_MUL: begin
				r_q <= scaled[25:8];
			end
			ST_UPD: begin
				acc_q <= (kind_q == bvg_pkg::KIND_SEED) ||
				         (r_q > bvg_pkg::WIN_LOW_Q4 && r_q < bvg_pkg::WIN_HIGH_Q4);
			end
			ST_HIST: begin
				base_q <= seg_base;
				diff_q <= seg_diff;
				dp_q   <= seg_dp;
				den_q  <= seg_den;
			end
			ST_PREP: begin
				rem_q   <= {mul_p[15:0], 1'b0} + {5'd0, den_q};
				denom_q <= {den_q, 1'b0};
				quo_q   <= 4'd0;
				bit_q   <= 2'd3;
				cs_q    <= cs_next;
			end
			ST_DIV: begin
				if (rem_q >= dsh) begin
					rem_q        <= rem_q - dsh;
					quo_q[bit_q] <= 1'b1;
				end
				bit_q <= bit_q - 2'd1;
			end
			default: begin
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_FIN && (!out_valid_q || m_axis_tready)) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && (!out_valid_q || m_axis_tready)) begin
			out_data_q <= {1'b0, acc_q, cs_q, base_q + {3'd0, quo_q}, mv_now};
		end
	end

endmodule

/* bench/tb_battery_voltage_gauge_top.sv */
// testbench for the battery voltage gauge: directed and random readings, checked by a gauge predictor
module tb_battery_voltage_gauge_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic KIND_READING = 1'b0;
	localparam int   IDLE_PCT     = 38;
	localparam int   SETTLE_CYCLES = 24;
	localparam int   CYCLE_LIMIT  = 400000;
	localparam int   WIN_LOW_MV   = 2000;
	localparam int   WIN_HIGH_MV  = 5000;

	// report fields, highest bits first
	typedef struct packed {
		logic        reading_accepted;
		logic [1:0]  charge_state;
		logic [6:0]  percent;
		logic [12:0] voltage_mv;
	} gauge_report_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata = '0;
	logic        s_axis_tuser = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [13:0] cfg_data = '0;

	// gauge state as the block should hold it
	int unsigned   scale_q12;
	int unsigned   avg_q4;
	int unsigned   hist_mv [bvg_pkg::HIST_DEPTH];
	int unsigned   hist_slot;
	bit            hist_wrapped;
	gauge_report_t pending_reports [$];

	int  mismatch_count = 0;
	int  cycle_count = 0;
	bit  steady = 1'b0;
	int  target_mv = 3900;
	int  drift = 0;

	battery_voltage_gauge_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	// clock
	always #4 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// receiver back-pressure
	always @(negedge clk) begin
		m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
	end

	// q4 millivolts to whole millivolts, half up, saturated
	function automatic int unsigned mv_of(int unsigned q4);
		int unsigned mv;
		mv = (q4 + 8) >> 4;
		return (mv > int'(bvg_pkg::MV_MAX)) ? int'(bvg_pkg::MV_MAX) : mv;
	endfunction

	// piecewise-linear state of charge
	function automatic int unsigned soc_of(int unsigned v);
		int unsigned lo, hi, den, dp, num;
		if (v >= int'(bvg_pkg::SOC_MV_Q4[0]))
			return 100;
		for (int i = 1; i < bvg_pkg::TABLE_POINTS; i++) begin
			lo = 32'(bvg_pkg::SOC_MV_Q4[i]);
			hi = 32'(bvg_pkg::SOC_MV_Q4[i-1]);
			if (v >= lo) begin
				den = hi - lo;
				dp  = 32'(bvg_pkg::SOC_PCT[i-1]) - 32'(bvg_pkg::SOC_PCT[i]);
				num = (v - lo) * dp * 2 + den;
				return 32'(bvg_pkg::SOC_PCT[i]) + num / (2 * den);
			end
		end
		return 0;
	endfunction

	// full, charging or discharging from thresholds and rise over the oldest entry
	function automatic logic [1:0] judge_charge(int unsigned v);
		if (v >= int'(bvg_pkg::FULL_Q4))
			return bvg_pkg::CS_FULL;
		if (v >= int'(bvg_pkg::CHARGING_Q4))
			return bvg_pkg::CS_CHARGING;
		if ((hist_wrapped || hist_slot > 3) &&
		    v > hist_mv[hist_slot] * 16 + int'(bvg_pkg::RISE_Q4))
			return bvg_pkg::CS_CHARGING;
		return bvg_pkg::CS_DISCHARGING;
	endfunction

	// advance the gauge by one reading and form its report
	function automatic gauge_report_t gauge_step(logic kind, int unsigned adc, logic tick);
		gauge_report_t rep;
		int unsigned   r;
		logic          acc;
		r   = (adc * scale_q12 + 128) >> 8;
		acc = 1'b0;
		if (kind == bvg_pkg::KIND_SEED) begin
			avg_q4 = (r > int'(bvg_pkg::Q4_MAX)) ? int'(bvg_pkg::Q4_MAX) : r;
			for (int i = 0; i < bvg_pkg::HIST_DEPTH; i++)
				hist_mv[i] = mv_of(avg_q4);
			hist_slot    = 0;
			hist_wrapped = 1'b0;
			acc          = 1'b1;
		end else begin
			if (r > int'(bvg_pkg::WIN_LOW_Q4) && r < int'(bvg_pkg::WIN_HIGH_Q4)) begin
				avg_q4 = (3 * avg_q4 + r + 2) >> 2;
				acc    = 1'b1;
			end
			if (tick) begin
				hist_mv[hist_slot] = mv_of(avg_q4);
				hist_slot++;
				if (hist_slot >= bvg_pkg::HIST_DEPTH) begin
					hist_slot    = 0;
					hist_wrapped = 1'b1;
				end
			end
		end
		rep.voltage_mv       = 13'(mv_of(avg_q4));
		rep.percent          = 7'(soc_of(avg_q4));
		rep.charge_state     = judge_charge(avg_q4);
		rep.reading_accepted = acc;
		return rep;
	endfunction

	// report checker
	always @(posedge clk) begin
		gauge_report_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata[22:0];
			if (pending_reports.size() == 0) begin
				$display("%0t unexpected report: expected none, actual %h", $time, got);
				mismatch_count++;
			end else begin
				want = pending_reports.pop_front();
				if (got.voltage_mv !== want.voltage_mv) begin
					$display("%0t voltage_mv: expected %0d, actual %0d",
						$time, want.voltage_mv, got.voltage_mv);
					mismatch_count++;
				end
				if (got.percent !== want.percent) begin
					$display("%0t percent: expected %0d, actual %0d",
						$time, want.percent, got.percent);
					mismatch_count++;
				end
				if (got.charge_state !== want.charge_state) begin
					$display("%0t charge_state: expected %0d, actual %0d",
						$time, want.charge_state, got.charge_state);
					mismatch_count++;
				end
				if (got.reading_accepted !== want.reading_accepted) begin
					$display("%0t reading_accepted: expected %0d, actual %0d",
						$time, want.reading_accepted, got.reading_accepted);
					mismatch_count++;
				end
			end
		end
	end

	// one reading transaction, with random idle cycles ahead of it
	task automatic send_reading(logic kind, int unsigned adc, logic tick);
		@(negedge clk);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= kind;
		s_axis_tdata  <= {3'b000, tick, adc[11:0]};
		do @(posedge clk); while (!s_axis_tready);
		pending_reports.push_back(gauge_step(kind, adc, tick));
	endtask

	// stop sending and wait until every report is back and the block is quiet
	task automatic drain_reports();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// divider ratio write, only with the block idle
	task automatic write_scale(int unsigned value);
		drain_reports();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value[13:0];
		do @(posedge clk); while (!cfg_ready);
		scale_q12 = value & 16'h3FFF;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// reset average seen through a reading outside the window
	task automatic test_reset_state();
		send_reading(KIND_READING, 0, 1'b0);
	endtask

	// plausibility window edges at unit and top ratio
	task automatic test_window_edges();
		write_scale(4096);
		send_reading(KIND_READING, WIN_LOW_MV, 1'b0);
		send_reading(KIND_READING, WIN_LOW_MV + 1, 1'b1);
		send_reading(KIND_READING, 4095, 1'b0);
		write_scale(16383);
		send_reading(KIND_READING, 1250, 1'b0);
		send_reading(KIND_READING, 1251, 1'b1);
	endtask

	// seeds on and around the table points, charging threshold included
	task automatic test_table_points();
		write_scale(4096);
		send_reading(bvg_pkg::KIND_SEED, 4095, 1'b0);
		send_reading(bvg_pkg::KIND_SEED, 3199, 1'b0);
		send_reading(bvg_pkg::KIND_SEED, 3200, 1'b0);
		send_reading(bvg_pkg::KIND_SEED, 3655, 1'b0);
		send_reading(bvg_pkg::KIND_SEED, 3900, 1'b0);
		send_reading(bvg_pkg::KIND_SEED, 4050, 1'b0);
	endtask

	// rising readings against a seeded history, charging once enough entries exist
	task automatic test_rise_detect();
		send_reading(bvg_pkg::KIND_SEED, 3700, 1'b1);
		repeat (6)
			send_reading(KIND_READING, 4000, 1'b1);
	endtask

	// seed saturation and seed of zero, tick ignored on seeds
	task automatic test_seed_saturation();
		write_scale(16383);
		send_reading(bvg_pkg::KIND_SEED, 4095, 1'b1);
		send_reading(KIND_READING, 1000, 1'b1);
		send_reading(bvg_pkg::KIND_SEED, 0, 1'b1);
	endtask

	// battery-like random walk with seeds, noise and window-edge readings
	task automatic test_random_walk(int n, int unsigned scale, bit no_idle);
		int  pick, adc, edge_mv;
		logic kind, tick;
		write_scale(scale);
		steady = no_idle;
		for (int i = 0; i < n; i++) begin
			if (i % 50 == 0)
				drift = int'($urandom_range(2)) - 1;
			target_mv += drift * int'($urandom_range(8)) + int'($urandom_range(10)) - 5;
			if ($urandom_range(99) < 2)
				target_mv = $urandom_range(WIN_HIGH_MV, WIN_LOW_MV);
			if (target_mv < 3000 || target_mv > 4400)
				target_mv = $urandom_range(4300, 3100);
			kind = ($urandom_range(99) < 3) ? bvg_pkg::KIND_SEED : KIND_READING;
			tick = $urandom_range(99) < 35;
			pick = $urandom_range(99);
			if (pick < 70) begin
				adc = (target_mv * 4096 + int'(scale) / 2) / int'(scale);
			end else if (pick < 85) begin
				adc = $urandom_range(4095);
			end else begin
				edge_mv = $urandom_range(1) ? WIN_LOW_MV : WIN_HIGH_MV;
				adc = (edge_mv * 4096) / int'(scale) + int'($urandom_range(4)) - 2;
			end
			if (adc > 4095)
				adc = 4095;
			if (adc < 0)
				adc = 0;
			send_reading(kind, adc, tick);
		end
		steady = 1'b0;
	endtask

	// reset, tests in turn, then wait for the last reports
	initial begin
		scale_q12    = 32'(bvg_pkg::SCALE_RESET);
		avg_q4       = 32'(bvg_pkg::Q4_RESET);
		hist_slot    = 0;
		hist_wrapped = 1'b0;
		for (int i = 0; i < bvg_pkg::HIST_DEPTH; i++)
			hist_mv[i] = 32'(bvg_pkg::MV_RESET);
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		test_reset_state();
		test_window_edges();
		test_table_points();
		test_rise_detect();
		test_seed_saturation();
		test_random_walk(250, 32'(bvg_pkg::SCALE_RESET), 1'b0);
		test_random_walk(150, 16383, 1'b0);
		test_random_walk(150, 4096, 1'b0);
		test_random_walk(150, $urandom_range(16382, 4097), 1'b1);

		drain_reports();
		if (mismatch_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
